### rtl/fdtw_pkg.sv
// fdtw_pkg: shared types, token values, event and error codes for the
// device tree structure walker; no dependencies
package fdtw_pkg;

    localparam int DEF_MAX_DEPTH = 255;

    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_END        = 32'd9;

    localparam logic [2:0] EV_NAME     = 3'd0;
    localparam logic [2:0] EV_NAME_END = 3'd1;
    localparam logic [2:0] EV_HEADER   = 3'd2;
    localparam logic [2:0] EV_DATA     = 3'd3;
    localparam logic [2:0] EV_DONE     = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    localparam logic [2:0] ERR_UNEXP_END      = 3'd0;
    localparam logic [2:0] ERR_UNEXP_NODE_END = 3'd1;
    localparam logic [2:0] ERR_PROP_NO_NODE   = 3'd2;
    localparam logic [2:0] ERR_BAD_TOKEN      = 3'd3;
    localparam logic [2:0] ERR_INCOMPLETE     = 3'd4;
    localparam logic [2:0] ERR_DEPTH          = 3'd5;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_NAME,
        PH_PAD,
        PH_LEN,
        PH_OFF,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  node_depth;
        logic [7:0]  value_byte;
        logic [31:0] prop_length;
        logic [31:0] name_offset;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_result;

    // results produced by one byte, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    function automatic t_result mk_res(logic [2:0] kind, logic [7:0] val,
                                       logic [31:0] len, logic [31:0] off,
                                       logic [2:0] err);
        t_result r;
        r.event_kind  = kind;
        r.node_depth  = 8'd0;
        r.value_byte  = val;
        r.prop_length = len;
        r.name_offset = off;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

### rtl/fdtw_core.sv
// fdtw_core: input register and walker state; decodes one byte per cycle
// into up to two results while i_room is high. depends on fdtw_pkg
module fdtw_core #(
    parameter int MAX_DEPTH = fdtw_pkg::DEF_MAX_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last,
    input  logic            i_stop,
    input  logic            i_room,
    output fdtw_pkg::t_push o_push
);
    import fdtw_pkg::*;

    localparam logic [7:0] LIMIT = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_byte;
    logic        r_last, r_stop;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_biw, n_biw;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_depth, n_depth;
    logic [31:0] r_held_len, n_held_len;
    logic [31:0] r_left, n_left;
    logic        r_finished, n_finished;

    logic        consume;
    logic [1:0]  pos_next;
    logic [31:0] acc_shift;
    logic [31:0] left_dec;
    logic        ended;
    t_push       push;

    assign consume  = r_in_valid && i_room;
    assign o_ready  = !r_in_valid || consume;
    assign pos_next = r_biw + 2'd1;
    assign acc_shift = {r_acc[23:0], r_byte};
    assign left_dec  = (r_left != 32'd0) ? r_left - 32'd1 : r_left;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_ready) begin
            n_in_valid = i_valid;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_biw      = r_biw;
        n_acc      = r_acc;
        n_depth    = r_depth;
        n_held_len = r_held_len;
        n_left     = r_left;
        n_finished = r_finished;
        ended      = 1'b0;
        push.count = 2'd0;
        push.slot0 = mk_res(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
        push.slot1 = mk_res(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);

        if (!r_finished) begin
            case (r_phase)
                PH_TOKEN: begin
                    n_acc = acc_shift;
                    if (pos_next == 2'd0) begin
                        if (acc_shift == TOK_END) begin
                            push.count = 2'd1;
                            if (r_depth != 8'd0) begin
                                push.slot0 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0,
                                                    ERR_UNEXP_END);
                            end
                            ended = 1'b1;
                        end else if (acc_shift == TOK_BEGIN_NODE) begin
                            if (r_depth >= LIMIT) begin
                                push.count = 2'd1;
                                push.slot0 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0,
                                                    ERR_DEPTH);
                                ended = 1'b1;
                            end else begin
                                n_depth = r_depth + 8'd1;
                                n_phase = PH_NAME;
                            end
                        end else if (acc_shift == TOK_END_NODE) begin
                            if (r_depth == 8'd0) begin
                                push.count = 2'd1;
                                push.slot0 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0,
                                                    ERR_UNEXP_NODE_END);
                                ended = 1'b1;
                            end else begin
                                n_depth = r_depth - 8'd1;
                            end
                        end else if (acc_shift == TOK_PROP) begin
                            if (r_depth == 8'd0) begin
                                push.count = 2'd1;
                                push.slot0 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0,
                                                    ERR_PROP_NO_NODE);
                                ended = 1'b1;
                            end else begin
                                n_phase = PH_LEN;
                            end
                        end else begin
                            push.count = 2'd1;
                            push.slot0 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0,
                                                ERR_BAD_TOKEN);
                            ended = 1'b1;
                        end
                    end
                end
                PH_NAME: begin
                    push.count = 2'd1;
                    if (r_byte != 8'd0) begin
                        push.slot0 = mk_res(EV_NAME, r_byte, 32'd0, 32'd0, 3'd0);
                    end else begin
                        push.slot0 = mk_res(EV_NAME_END, 8'd0, 32'd0, 32'd0, 3'd0);
                        n_phase = (pos_next != 2'd0) ? PH_PAD : PH_TOKEN;
                        if (r_stop) begin
                            push.count = 2'd2;
                            ended = 1'b1;
                        end
                    end
                end
                PH_PAD: begin
                    if (pos_next == 2'd0) begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_LEN: begin
                    n_acc = acc_shift;
                    if (pos_next == 2'd0) begin
                        n_held_len = acc_shift;
                        n_phase    = PH_OFF;
                    end
                end
                PH_OFF: begin
                    n_acc = acc_shift;
                    if (pos_next == 2'd0) begin
                        push.count = 2'd1;
                        push.slot0 = mk_res(EV_HEADER, 8'd0, r_held_len, acc_shift,
                                            3'd0);
                        n_left = r_held_len;
                        if (r_held_len == 32'd0) begin
                            n_phase = PH_TOKEN;
                            if (r_stop) begin
                                push.count = 2'd2;
                                ended = 1'b1;
                            end
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                default: begin
                    push.count = 2'd1;
                    push.slot0 = mk_res(EV_DATA, r_byte, 32'd0, 32'd0, 3'd0);
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = (pos_next != 2'd0) ? PH_PAD : PH_TOKEN;
                        if (r_stop) begin
                            push.count = 2'd2;
                            ended = 1'b1;
                        end
                    end
                end
            endcase

            n_biw = pos_next;

            // stream end closes the walk
            if (!ended && r_last) begin
                if (n_phase == PH_TOKEN && pos_next != 2'd0) begin
                    push.slot1 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_BAD_TOKEN);
                end else if ((n_phase == PH_TOKEN || n_phase == PH_PAD)
                             && n_depth == 8'd0) begin
                    push.slot1 = mk_res(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
                end else begin
                    push.slot1 = mk_res(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_INCOMPLETE);
                end
                if (push.count == 2'd0) begin
                    push.slot0 = push.slot1;
                    push.count = 2'd1;
                end else begin
                    push.count = 2'd2;
                end
                ended = 1'b1;
            end
            if (ended) begin
                n_finished = 1'b1;
            end
        end

        push.slot0.node_depth = n_depth;
        push.slot1.node_depth = n_depth;
        push.slot0.last_of_run = (push.count == 2'd1);
        push.slot1.last_of_run = 1'b1;

        if (r_last) begin
            n_phase    = PH_TOKEN;
            n_biw      = 2'd0;
            n_acc      = 32'd0;
            n_depth    = 8'd0;
            n_held_len = 32'd0;
            n_left     = 32'd0;
            n_finished = 1'b0;
        end
    end

    always_comb begin
        o_push = push;
        if (!consume) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_byte <= i_data_byte;
            r_last <= i_last;
            r_stop <= i_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_TOKEN;
            r_biw      <= 2'd0;
            r_acc      <= 32'd0;
            r_depth    <= 8'd0;
            r_held_len <= 32'd0;
            r_left     <= 32'd0;
            r_finished <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (consume) begin
                r_phase    <= n_phase;
                r_biw      <= n_biw;
                r_acc      <= n_acc;
                r_depth    <= n_depth;
                r_held_len <= n_held_len;
                r_left     <= n_left;
                r_finished <= n_finished;
            end
        end
    end

endmodule

### rtl/fdtw_out_queue.sv
// fdtw_out_queue: three-entry shift queue of results, takes up to two per
// cycle and hands out one per transaction. depends on fdtw_pkg
module fdtw_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdtw_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output fdtw_pkg::t_result o_head
);
    import fdtw_pkg::*;

    localparam int DEPTH = 3;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    logic [1:0] r_count, n_count;
    logic       pop;
    logic [1:0] base;

    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_ready;
    // room for two results regardless of the output side
    assign o_room  = (r_count <= 2'd1);
    assign base    = r_count - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push.count != 2'd0 && 2'(i) == base) begin
                n_q[i] = i_push.slot0;
            end
            if (i_push.count == 2'd2 && 2'(i) == base + 2'd1) begin
                n_q[i] = i_push.slot1;
            end
        end
        n_count = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### rtl/flat_device_tree_walker.sv
// Structure-block walker for a flattened device tree: one byte of the block
// is taken per cycle with valid/ready while the result queue has room, and
// node-name, name-end, property header, property data, done and error events
// come out one per output transaction. A byte enters an input register, is
// decoded against the walker state and its events land in a three-entry
// result queue once it has room, so the first event of a byte shows after the
// input register and the queue. The sustained rate is one byte per cycle while
// the output keeps up; a byte that yields two events (a completion followed by
// done, or a stream-end event) takes two output transactions, and the queue
// holds the second. A node deeper than min(MAX_DEPTH, 255) ends in an error.
// Depends on fdtw_pkg, fdtw_core and fdtw_out_queue.
module flat_device_tree_walker #(
    parameter int MAX_DEPTH = fdtw_pkg::DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_stop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_node_depth,
    output logic [7:0]  o_value_byte,
    output logic [31:0] o_prop_length,
    output logic [31:0] o_name_offset,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);
    import fdtw_pkg::*;

    t_push   push;
    logic    room;
    t_result head;

    fdtw_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_stop      (i_stop),
        .i_room      (room),
        .o_push      (push)
    );

    fdtw_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_event_kind  = head.event_kind;
    assign o_node_depth  = head.node_depth;
    assign o_value_byte  = head.value_byte;
    assign o_prop_length = head.prop_length;
    assign o_name_offset = head.name_offset;
    assign o_error_code  = head.error_code;
    assign o_last_of_run = head.last_of_run;

endmodule

### tb/testbench.sv
// testbench for flat_device_tree_walker: random and directed structure blocks
// are checked against an in-house walk predictor; needs fdtw_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdtw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       stop;
    } t_stream_byte;

    // predicts walker events per accepted byte and checks them in order
    class dt_event_scoreboard;
        t_phase      ph;
        bit [1:0]    pos;
        bit [31:0]   acc;
        bit [7:0]    depth;
        bit [31:0]   held_len;
        bit [31:0]   left;
        bit          walk_over;
        int          depth_limit;
        t_result     run_q[$];
        t_result     expected_events[$];
        int          failures;
        int          checked;
        int          deepest;

        function new(int max_depth);
            depth_limit = (max_depth < 255) ? max_depth : 255;
            failures = 0;
            checked = 0;
            deepest = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            ph = PH_TOKEN;
            pos = 2'd0;
            acc = 32'd0;
            depth = 8'd0;
            held_len = 32'd0;
            left = 32'd0;
            walk_over = 1'b0;
        endfunction

        function void emit(logic [2:0] kind, logic [7:0] val, logic [31:0] len,
                           logic [31:0] off, logic [2:0] err);
            t_result r;
            r.event_kind  = kind;
            r.node_depth  = depth;
            r.value_byte  = val;
            r.prop_length = len;
            r.name_offset = off;
            r.error_code  = err;
            r.last_of_run = 1'b0;
            run_q.push_back(r);
        endfunction

        function void end_or_done(logic [2:0] err);
            if (depth != 8'd0) emit(EV_ERROR, 8'd0, 32'd0, 32'd0, err);
            else emit(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
        endfunction

        // returns 0 when the byte is ignored after the walk has ended
        function bit note_byte(bit [7:0] b, bit last, bit stop);
            bit [1:0] nxt;
            bit       ended;
            t_result  r;
            if (walk_over) begin
                if (last) clear_walk();
                return 1'b0;
            end
            run_q.delete();
            ended = 1'b0;
            nxt = pos + 2'd1;
            case (ph)
                PH_TOKEN: begin
                    acc = {acc[23:0], b};
                    if (nxt == 2'd0) begin
                        if (acc == TOK_END) begin
                            end_or_done(ERR_UNEXP_END);
                            ended = 1'b1;
                        end else if (acc == TOK_BEGIN_NODE) begin
                            if (depth >= depth_limit) begin
                                emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_DEPTH);
                                ended = 1'b1;
                            end else begin
                                depth++;
                                ph = PH_NAME;
                            end
                        end else if (acc == TOK_END_NODE) begin
                            if (depth == 8'd0) begin
                                emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_UNEXP_NODE_END);
                                ended = 1'b1;
                            end else begin
                                depth--;
                            end
                        end else if (acc == TOK_PROP) begin
                            if (depth == 8'd0) begin
                                emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_PROP_NO_NODE);
                                ended = 1'b1;
                            end else begin
                                ph = PH_LEN;
                            end
                        end else begin
                            emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_BAD_TOKEN);
                            ended = 1'b1;
                        end
                    end
                end
                PH_NAME: begin
                    if (b != 8'd0) begin
                        emit(EV_NAME, b, 32'd0, 32'd0, 3'd0);
                    end else begin
                        emit(EV_NAME_END, 8'd0, 32'd0, 32'd0, 3'd0);
                        ph = (nxt != 2'd0) ? PH_PAD : PH_TOKEN;
                        if (stop) begin
                            emit(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
                            ended = 1'b1;
                        end
                    end
                end
                PH_PAD: begin
                    if (nxt == 2'd0) ph = PH_TOKEN;
                end
                PH_LEN: begin
                    acc = {acc[23:0], b};
                    if (nxt == 2'd0) begin
                        held_len = acc;
                        ph = PH_OFF;
                    end
                end
                PH_OFF: begin
                    acc = {acc[23:0], b};
                    if (nxt == 2'd0) begin
                        emit(EV_HEADER, 8'd0, held_len, acc, 3'd0);
                        left = held_len;
                        if (left == 32'd0) begin
                            ph = PH_TOKEN;
                            if (stop) begin
                                emit(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
                                ended = 1'b1;
                            end
                        end else begin
                            ph = PH_DATA;
                        end
                    end
                end
                default: begin
                    emit(EV_DATA, b, 32'd0, 32'd0, 3'd0);
                    if (left != 32'd0) left--;
                    if (left == 32'd0) begin
                        ph = (nxt != 2'd0) ? PH_PAD : PH_TOKEN;
                        if (stop) begin
                            emit(EV_DONE, 8'd0, 32'd0, 32'd0, 3'd0);
                            ended = 1'b1;
                        end
                    end
                end
            endcase
            pos = nxt;
            if (!ended && last) begin
                if (ph == PH_TOKEN && pos != 2'd0)
                    emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_BAD_TOKEN);
                else if (ph == PH_TOKEN || ph == PH_PAD)
                    end_or_done(ERR_INCOMPLETE);
                else
                    emit(EV_ERROR, 8'd0, 32'd0, 32'd0, ERR_INCOMPLETE);
                ended = 1'b1;
            end
            if (depth > deepest) deepest = depth;
            if (ended) walk_over = 1'b1;
            if (last) clear_walk();
            if (run_q.size() > 0) begin
                r = run_q.pop_back();
                r.last_of_run = 1'b1;
                run_q.push_back(r);
            end
            foreach (run_q[i]) expected_events.push_back(run_q[i]);
            return 1'b1;
        endfunction

        function void cmp(string fname, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", fname, want, got);
                failures++;
            end
        endfunction

        function void check_event(t_result got);
            t_result want;
            if (expected_events.size() == 0) begin
                $error("event with nothing expected: kind %0d depth %0d",
                       got.event_kind, got.node_depth);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            checked++;
            cmp("event_kind", want.event_kind, got.event_kind);
            cmp("node_depth", want.node_depth, got.node_depth);
            cmp("value_byte", want.value_byte, got.value_byte);
            cmp("prop_length", want.prop_length, got.prop_length);
            cmp("name_offset", want.name_offset, got.name_offset);
            cmp("error_code", want.error_code, got.error_code);
            cmp("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        i_stop;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_node_depth;
    logic [7:0]  o_value_byte;
    logic [31:0] o_prop_length;
    logic [31:0] o_name_offset;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    flat_device_tree_walker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_stop        (i_stop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_kind  (o_event_kind),
        .o_node_depth  (o_node_depth),
        .o_value_byte  (o_value_byte),
        .o_prop_length (o_prop_length),
        .o_name_offset (o_name_offset),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    dt_event_scoreboard sb;
    t_stream_byte       walk_q[$];
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 stop_pct;
    bit                 hold_req;
    int                 bytes_sent;
    int                 bytes_walked;
    int                 walks_sent;
    int                 quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---- stream building ----

    task automatic add_byte(bit [7:0] b);
        t_stream_byte it;
        it.b = b;
        it.last = 1'b0;
        it.stop = ($urandom_range(0, 99) < stop_pct);
        walk_q.push_back(it);
    endtask

    task automatic add_word(bit [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    task automatic add_pad();
        while (walk_q.size() % 4 != 0) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic mark_tail(bit set_last, bit set_stop);
        t_stream_byte it;
        it = walk_q.pop_back();
        if (set_last) it.last = 1'b1;
        if (set_stop) it.stop = 1'b1;
        walk_q.push_back(it);
    endtask

    task automatic add_name(int n, bit stop_end);
        repeat (n) add_byte(8'($urandom_range(1, 255)));
        add_byte(8'h00);
        if (stop_end) mark_tail(1'b0, 1'b1);
        add_pad();
    endtask

    task automatic add_prop(bit [31:0] len, bit [31:0] off, bit stop_end);
        add_word(TOK_PROP);
        add_word(len);
        add_word(off);
        repeat (len) add_byte(8'($urandom_range(0, 255)));
        if (stop_end) mark_tail(1'b0, 1'b1);
        add_pad();
    endtask

    task automatic cut_to(int n);
        while (walk_q.size() > n) void'(walk_q.pop_back());
    endtask

    // ---- driving ----

    task automatic send_byte(t_stream_byte it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= it.b;
        i_last <= it.last;
        i_stop <= it.stop;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (sb.note_byte(it.b, it.last, it.stop)) bytes_walked++;
    endtask

    task automatic send_walk();
        mark_tail(1'b1, 1'b0);
        foreach (walk_q[i]) send_byte(walk_q[i]);
        walk_q.delete();
        walks_sent++;
    endtask

    task automatic random_tree();
        int d;
        add_word(TOK_BEGIN_NODE);
        add_name($urandom_range(0, 9), 1'b0);
        d = 1;
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 3))
                0: if (d < 6) begin
                    add_word(TOK_BEGIN_NODE);
                    add_name($urandom_range(0, 9), 1'b0);
                    d++;
                end
                1: if (d > 1) begin
                    add_word(TOK_END_NODE);
                    d--;
                end
                default: add_prop(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                               : $urandom_range(0, 9),
                                  $urandom(), 1'b0);
            endcase
        end
        while (d > 0) begin
            add_word(TOK_END_NODE);
            d--;
        end
        case ($urandom_range(0, 9))
            0: ;  // stream ends on a word boundary without the end token
            1: begin
                add_word(TOK_END);
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            default: add_word(TOK_END);
        endcase
    endtask

    task automatic run_directed();
        add_word(TOK_END);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(3, 1'b0);
        add_prop(32'd0, 32'hFFFF_FFFF, 1'b0);
        add_word(TOK_PROP);
        add_word(32'd5);
        add_word(32'd0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        add_byte(8'hAA);
        add_byte(8'h00);
        add_pad();
        add_word(TOK_END_NODE);
        add_word(TOK_END);
        send_walk();
        add_word(TOK_END_NODE);
        send_walk();
        add_word(TOK_PROP);
        send_walk();
        add_word(32'hFFFF_FFFF);
        add_byte(8'h12);
        add_byte(8'h34);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(2, 1'b0);
        add_word(TOK_END);
        send_walk();
        // early stop on name end, on an empty property and on the last data byte
        add_word(TOK_BEGIN_NODE);
        add_name(1, 1'b1);
        add_word(TOK_END_NODE);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(4, 1'b0);
        add_prop(32'd0, 32'h0000_0010, 1'b1);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(0, 1'b0);
        add_prop(32'd3, 32'h8000_0000, 1'b1);
        send_walk();
        // stream end inside a token, name, length, offset, data and padding
        add_word(TOK_BEGIN_NODE);
        cut_to(2);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(6, 1'b0);
        cut_to(7);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(0, 1'b0);
        add_prop(32'd4, 32'd1, 1'b0);
        cut_to(14);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(0, 1'b0);
        add_prop(32'd4, 32'd1, 1'b0);
        cut_to(19);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(0, 1'b0);
        add_word(TOK_PROP);
        add_word(32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFF);
        add_byte(8'hFF);
        add_byte(8'h01);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(1, 1'b0);
        cut_to(7);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(3, 1'b0);
        send_walk();
        add_word(TOK_BEGIN_NODE);
        add_name(2, 1'b0);
        add_word(TOK_END_NODE);
        send_walk();
    endtask

    // ---- receiver ----

    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                sb.check_event({o_event_kind, o_node_depth, o_value_byte, o_prop_length,
                                o_name_offset, o_error_code, o_last_of_run});
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                // long hold-off so the walker backs up and stalls its input
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // ---- watchdog: cycles with no transaction on either side ----

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("flat_device_tree_walker verification failed");
                $finish;
            end
        end
    end

    // ---- main sequence ----

    initial begin
        int target;
        int r;
        sb = new(DEF_MAX_DEPTH);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        stop_pct = 0;
        hold_req = 1'b0;
        bytes_sent = 0;
        bytes_walked = 0;
        walks_sent = 0;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data_byte <= 8'd0;
        i_last <= 1'b0;
        i_stop <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        stop_pct = 3;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  hold_req = 1'b1; end
                1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
                default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
            endcase
            target = bytes_walked + 120;
            while (bytes_walked < target) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
                end else begin
                    random_tree();
                    if (r < 30)
                        cut_to($urandom_range(1, walk_q.size()));
                    else if (r < 40)
                        walk_q[$urandom_range(0, walk_q.size() - 1)].b =
                            8'($urandom_range(0, 255));
                end
                send_walk();
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d walks, %0d bytes (%0d walked), %0d events checked",
                 walks_sent, bytes_sent, bytes_walked, sb.checked);
        $display("deepest nesting %0d, with idle, stall and hold-off phases", sb.deepest);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("flat_device_tree_walker verification clean");
        end else begin
            $display("flat_device_tree_walker verification failed");
        end
        $finish;
    end

endmodule
